### rtl/gda_pkg.sv
// ============================================================================
// gda_pkg
// Shared types and constants for the Gregorian date arithmetic unit: request
// command codes, result error codes, datapath micro-operations and the
// command/status bundles that join the controller to the datapath.
// ============================================================================
`default_nettype none

package gda_pkg;

   // Default width of the signed amount field.
   localparam int AMOUNT_BITS_DEF = 20;

   // Legal span of years.
   localparam int MIN_YEAR = 1753;
   localparam int MAX_YEAR = 9999;

   // Date held after reset.
   localparam int RESET_YEAR  = 1970;
   localparam int RESET_MONTH = 1;
   localparam int RESET_DAY   = 1;

   // Request command codes.
   typedef enum logic [1:0] {
      CMD_LOAD       = 2'd0,
      CMD_ADD_DAYS   = 2'd1,
      CMD_ADD_MONTHS = 2'd2,
      CMD_ADD_YEARS  = 2'd3
   } req_cmd_type;

   // Result error codes.
   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_BAD_LOAD = 2'd1,
      ERR_RANGE    = 2'd2
   } err_code_type;

   // Datapath micro-operations issued by the controller.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_DIV100,
      OP_LEAP,
      OP_WALK,
      OP_MON_T,
      OP_MON_DIV,
      OP_MON_SET,
      OP_YR_T,
      OP_YR_SET,
      OP_CLAMP,
      OP_ERR_LOAD,
      OP_ERR_RANGE,
      OP_WD_DIV,
      OP_WD_SUM,
      OP_WD_DIV7,
      OP_WD_MOD,
      OP_COMMIT
   } dp_op_type;

   // Command bundle from the controller to the datapath.
   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   // Status bundle from the datapath to the controller.
   typedef struct packed {
      logic load_ok;   // loaded date is a valid calendar date
      logic day_fit;   // remaining days land inside the current month
      logic year_oob;  // working year has left the legal span
      logic mon_oob;   // month total lies outside the legal span
      logic yr_oob;    // year total lies outside the legal span
      logic out_free;  // result register can take a new result
   } dp_status_type;

endpackage

`default_nettype wire

### rtl/gregorian_date_arithmetic_unit.sv
// The day walk steps one month per cycle.
// One request is in flight at a time; the next is taken the cycle after commit.
// Synchronous reset clears the control state and sets the date to 1970-01-01.
// ============================================================================
// gregorian_date_arithmetic_unit
// Holds one Gregorian date and applies load, add-days, add-months and
// add-years requests, returning the new date, its weekday and an error code.
// ============================================================================
`default_nettype none

module gregorian_date_arithmetic_unit #(
   parameter int AMOUNT_BITS = gda_pkg::AMOUNT_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_cmd,
   input  wire logic signed [AMOUNT_BITS-1:0] req_amount,
   input  wire logic [13:0]                   req_load_year,
   input  wire logic [3:0]                    req_load_month,
   input  wire logic [4:0]                    req_load_day,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [13:0]                        rsp_year,
   output logic [3:0]                         rsp_month,
   output logic [4:0]                         rsp_day,
   output logic [2:0]                         rsp_weekday,
   output logic [1:0]                         rsp_error
);
   import gda_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Sequencer.
   gda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // Date registers and arithmetic.
   gda_datapath #(
      .AMOUNT_BITS (AMOUNT_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .dp_status      (dp_status),
      .req_cmd        (req_cmd),
      .req_amount     (req_amount),
      .req_load_year  (req_load_year),
      .req_load_month (req_load_month),
      .req_load_day   (req_load_day),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_year       (rsp_year),
      .rsp_month      (rsp_month),
      .rsp_day        (rsp_day),
      .rsp_weekday    (rsp_weekday),
      .rsp_error      (rsp_error)
   );

endmodule

`default_nettype wire

### rtl/gda_ctrl.sv
// ============================================================================
// gda_ctrl
// Controller for the date arithmetic unit. Accepts one request at a time and
// steps the datapath through its micro-operations until the result is
// committed to the output register.
// ============================================================================
`default_nettype none

module gda_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [1:0]             req_cmd,
   input  wire gda_pkg::dp_status_type dp_status,
   output gda_pkg::dp_cmd_type         dp_cmd
);
   import gda_pkg::*;

   typedef enum logic [16:0] {
      S_IDLE   = 17'd1,
      S_DIV100 = 17'd2,
      S_LEAP   = 17'd4,
      S_LCHECK = 17'd8,
      S_WALK   = 17'd16,
      S_MTERM  = 17'd32,
      S_MDIV   = 17'd64,
      S_MSET   = 17'd128,
      S_YTERM  = 17'd256,
      S_YSET   = 17'd512,
      S_CLAMP  = 17'd1024,
      S_ERR    = 17'd2048,
      S_WDIV   = 17'd4096,
      S_WSUM   = 17'd8192,
      S_WDIV7  = 17'd16384,
      S_WMOD   = 17'd32768,
      S_DONE   = 17'd65536
   } state_type;

   state_type   state_ff, state_in;
   req_cmd_type cmd_ff, cmd_in;

   // A new request is taken only when no other is in flight.
   assign req_ready = (state_ff == S_IDLE);

   // Next state and micro-operation.
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      dp_cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.op = OP_CAPTURE;
               cmd_in    = req_cmd_type'(req_cmd);
               case (req_cmd_type'(req_cmd))
                  CMD_LOAD:       state_in = S_DIV100;
                  CMD_ADD_DAYS:   state_in = S_DIV100;
                  CMD_ADD_MONTHS: state_in = S_MTERM;
                  default:        state_in = S_YTERM;
               endcase
            end
         end
         S_DIV100: begin
            dp_cmd.op = OP_DIV100;
            state_in  = S_LEAP;
         end
         S_LEAP: begin
            dp_cmd.op = OP_LEAP;
            case (cmd_ff)
               CMD_LOAD:     state_in = S_LCHECK;
               CMD_ADD_DAYS: state_in = S_WALK;
               default:      state_in = S_CLAMP;
            endcase
         end
         S_LCHECK: begin
            state_in = dp_status.load_ok ? S_WDIV : S_ERR;
         end
         S_WALK: begin
            // One month per cycle until the remaining days fit.
            if (dp_status.year_oob) begin
               state_in = S_ERR;
            end else begin
               dp_cmd.op = OP_WALK;
               if (dp_status.day_fit) begin
                  state_in = S_WDIV;
               end
            end
         end
         S_MTERM: begin
            dp_cmd.op = OP_MON_T;
            state_in  = S_MDIV;
         end
         S_MDIV: begin
            if (dp_status.mon_oob) begin
               state_in = S_ERR;
            end else begin
               dp_cmd.op = OP_MON_DIV;
               state_in  = S_MSET;
            end
         end
         S_MSET: begin
            dp_cmd.op = OP_MON_SET;
            state_in  = S_DIV100;
         end
         S_YTERM: begin
            dp_cmd.op = OP_YR_T;
            state_in  = S_YSET;
         end
         S_YSET: begin
            if (dp_status.yr_oob) begin
               state_in = S_ERR;
            end else begin
               dp_cmd.op = OP_YR_SET;
               state_in  = S_DIV100;
            end
         end
         S_CLAMP: begin
            dp_cmd.op = OP_CLAMP;
            state_in  = S_WDIV;
         end
         S_ERR: begin
            dp_cmd.op = (cmd_ff == CMD_LOAD) ? OP_ERR_LOAD : OP_ERR_RANGE;
            state_in  = S_WDIV;
         end
         S_WDIV: begin
            dp_cmd.op = OP_WD_DIV;
            state_in  = S_WSUM;
         end
         S_WSUM: begin
            dp_cmd.op = OP_WD_SUM;
            state_in  = S_WDIV7;
         end
         S_WDIV7: begin
            dp_cmd.op = OP_WD_DIV7;
            state_in  = S_WMOD;
         end
         S_WMOD: begin
            dp_cmd.op = OP_WD_MOD;
            state_in  = S_DONE;
         end
         S_DONE: begin
            // Wait for the output register to drain before committing.
            if (dp_status.out_free) begin
               dp_cmd.op = OP_COMMIT;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cmd_ff   <= CMD_LOAD;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
      end
   end

endmodule

`default_nettype wire

### rtl/gda_datapath.sv
// ============================================================================
// gda_datapath
// Datapath for the date arithmetic unit: the stored date, a working copy, a
// month-by-month day walker with incremental leap-year tracking, the month
// and year adders, the weekday calculation and the result register.
// ============================================================================
`default_nettype none

module gda_datapath #(
   parameter int AMOUNT_BITS = gda_pkg::AMOUNT_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gda_pkg::dp_cmd_type           dp_cmd,
   output gda_pkg::dp_status_type             dp_status,
   input  wire logic [1:0]                    req_cmd,
   input  wire logic signed [AMOUNT_BITS-1:0] req_amount,
   input  wire logic [13:0]                   req_load_year,
   input  wire logic [3:0]                    req_load_month,
   input  wire logic [4:0]                    req_load_day,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [13:0]                        rsp_year,
   output logic [3:0]                         rsp_month,
   output logic [4:0]                         rsp_day,
   output logic [2:0]                         rsp_weekday,
   output logic [1:0]                         rsp_error
);
   import gda_pkg::*;

   // Width of the signed month or year total.
   localparam int TW = ((AMOUNT_BITS > 18) ? AMOUNT_BITS : 18) + 1;

   // Days in a month.
   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         4'd2:                    len = leap ? 5'd29 : 5'd28;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

   // Month term of the weekday sum, floor(31 * mm / 12) with March as month 1.
   function automatic logic [13:0] month_term(input logic [3:0] m);
      logic [13:0] v;
      case (m)
         4'd1:    v = 14'd28;
         4'd2:    v = 14'd31;
         4'd3:    v = 14'd2;
         4'd4:    v = 14'd5;
         4'd5:    v = 14'd7;
         4'd6:    v = 14'd10;
         4'd7:    v = 14'd12;
         4'd8:    v = 14'd15;
         4'd9:    v = 14'd18;
         4'd10:   v = 14'd20;
         4'd11:   v = 14'd23;
         default: v = 14'd25;
      endcase
      return v;
   endfunction

   // Stored date.
   logic [13:0] cur_year_ff, cur_year_in;
   logic [3:0]  cur_month_ff, cur_month_in;
   logic [4:0]  cur_day_ff, cur_day_in;

   // Working date.
   logic [13:0] w_year_ff, w_year_in;
   logic [3:0]  w_month_ff, w_month_in;
   logic [4:0]  w_day_ff, w_day_in;

   // Amount and day walker.
   logic signed [AMOUNT_BITS-1:0] amt_ff, amt_in;
   logic [AMOUNT_BITS-1:0]        rem_ff, rem_in;
   logic                          neg_ff, neg_in;

   // Month or year total and the quotient by twelve.
   logic signed [TW-1:0] t_ff, t_in;
   logic [13:0]          q12_ff, q12_in;

   // Leap-year tracking of the working year.
   logic [7:0]  q100_ff, q100_in;
   logic [1:0]  ymod4_ff, ymod4_in;
   logic [6:0]  ymod100_ff, ymod100_in;
   logic [1:0]  qmod4_ff, qmod4_in;

   // Weekday calculation.
   logic [13:0] wsum_ff, wsum_in;
   logic [11:0] q7_ff, q7_in;
   logic [2:0]  wd_ff, wd_in;

   // Error code and result register.
   err_code_type err_ff, err_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [13:0]  rsp_year_ff, rsp_year_in;
   logic [3:0]   rsp_month_ff, rsp_month_in;
   logic [4:0]   rsp_day_ff, rsp_day_in;
   logic [2:0]   rsp_wd_ff, rsp_wd_in;
   logic [1:0]   rsp_err_ff, rsp_err_in;

   // Combinational helpers.
   logic                   leap;
   logic [4:0]             len_cur;
   logic [4:0]             len_prev;
   logic [3:0]             prev_month;
   logic [4:0]             room;
   logic                   fit_fwd;
   logic                   fit_bwd;
   logic [13:0]            yy;
   logic [13:0]            div_opnd;
   logic [26:0]            prod100;
   logic [30:0]            prod12;
   logic [30:0]            prod7;
   logic [16:0]            t17;
   logic [13:0]            r100;
   logic [AMOUNT_BITS-1:0] amt_mag;
   logic [TW-1:0]          mon_base;

   // Leap flag of the working year from its tracked residues.
   assign leap = (ymod4_ff == 2'd0) && ((ymod100_ff != 7'd0) || (qmod4_ff == 2'd0));

   assign len_cur    = month_len(w_month_ff, leap);
   assign prev_month = (w_month_ff == 4'd1) ? 4'd12 : (w_month_ff - 4'd1);
   assign len_prev   = month_len(prev_month, leap);
   assign room       = len_cur - w_day_ff;
   assign fit_fwd    = (rem_ff <= AMOUNT_BITS'(room));
   assign fit_bwd    = (rem_ff < AMOUNT_BITS'(w_day_ff));

   // Year used by the weekday formula: January and February count to the year before.
   assign yy = (w_month_ff <= 4'd2) ? (w_year_ff - 14'd1) : w_year_ff;

   // Shared divide by one hundred: multiply by 5243 and drop 19 bits.
   assign div_opnd = (dp_cmd.op == OP_WD_DIV) ? yy : w_year_ff;
   assign prod100  = 27'(div_opnd) * 27'd5243;
   assign r100     = w_year_ff - 14'(q100_ff) * 14'd100;

   // Divide by twelve: quarter, then multiply by 43691 and drop 17 bits.
   assign t17    = t_ff[16:0];
   assign prod12 = 31'(t17[16:2]) * 31'd43691;

   // Divide by seven: multiply by 74899 and drop 19 bits.
   assign prod7 = 31'(wsum_ff) * 31'd74899;

   // Magnitude of the amount; the most negative value maps onto the sign bit.
   assign amt_mag = amt_ff[AMOUNT_BITS-1] ? AMOUNT_BITS'(-amt_ff) : AMOUNT_BITS'(amt_ff);

   // Months since year zero of the working date.
   assign mon_base = TW'({w_year_ff, 3'b000}) + TW'({w_year_ff, 2'b00})
                   + TW'(w_month_ff) - TW'(1);

   // Status to the controller.
   always_comb begin
      dp_status.load_ok  = (w_year_ff >= 14'(MIN_YEAR)) && (w_year_ff <= 14'(MAX_YEAR))
                        && (w_month_ff >= 4'd1) && (w_month_ff <= 4'd12)
                        && (w_day_ff >= 5'd1) && (w_day_ff <= len_cur);
      dp_status.day_fit  = neg_ff ? fit_bwd : fit_fwd;
      dp_status.year_oob = (w_year_ff < 14'(MIN_YEAR)) || (w_year_ff > 14'(MAX_YEAR));
      dp_status.mon_oob  = (t_ff < $signed(TW'(MIN_YEAR * 12)))
                        || (t_ff > $signed(TW'(MAX_YEAR * 12 + 11)));
      dp_status.yr_oob   = (t_ff < $signed(TW'(MIN_YEAR)))
                        || (t_ff > $signed(TW'(MAX_YEAR)));
      dp_status.out_free = !rsp_valid_ff || rsp_ready;
   end

   // Next values of every register.
   always_comb begin
      cur_year_in  = cur_year_ff;
      cur_month_in = cur_month_ff;
      cur_day_in   = cur_day_ff;
      w_year_in    = w_year_ff;
      w_month_in   = w_month_ff;
      w_day_in     = w_day_ff;
      amt_in       = amt_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      t_in         = t_ff;
      q12_in       = q12_ff;
      q100_in      = q100_ff;
      ymod4_in     = ymod4_ff;
      ymod100_in   = ymod100_ff;
      qmod4_in     = qmod4_ff;
      wsum_in      = wsum_ff;
      q7_in        = q7_ff;
      wd_in        = wd_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_year_in  = rsp_year_ff;
      rsp_month_in = rsp_month_ff;
      rsp_day_in   = rsp_day_ff;
      rsp_wd_in    = rsp_wd_ff;
      rsp_err_in   = rsp_err_ff;

      case (dp_cmd.op)
         OP_CAPTURE: begin
            // Take the request: the loaded date or the stored one.
            if (req_cmd_type'(req_cmd) == CMD_LOAD) begin
               w_year_in  = req_load_year;
               w_month_in = req_load_month;
               w_day_in   = req_load_day;
            end else begin
               w_year_in  = cur_year_ff;
               w_month_in = cur_month_ff;
               w_day_in   = cur_day_ff;
            end
            amt_in = req_amount;
            err_in = ERR_NONE;
         end
         OP_DIV100: begin
            q100_in = prod100[26:19];
            // The walker starts from the magnitude of the amount.
            rem_in  = amt_mag;
            neg_in  = amt_ff[AMOUNT_BITS-1];
         end
         OP_LEAP: begin
            ymod4_in   = w_year_ff[1:0];
            ymod100_in = r100[6:0];
            qmod4_in   = q100_ff[1:0];
         end
         OP_WALK: begin
            if (neg_ff ? fit_bwd : fit_fwd) begin
               // Remaining days land inside this month.
               w_day_in = neg_ff ? (w_day_ff - rem_ff[4:0]) : (w_day_ff + rem_ff[4:0]);
               rem_in   = '0;
            end else if (!neg_ff) begin
               // Forward to the first day of the next month.
               rem_in   = rem_ff - AMOUNT_BITS'(room) - AMOUNT_BITS'(1);
               w_day_in = 5'd1;
               if (w_month_ff == 4'd12) begin
                  w_month_in = 4'd1;
                  w_year_in  = w_year_ff + 14'd1;
                  ymod4_in   = ymod4_ff + 2'd1;
                  if (ymod100_ff == 7'd99) begin
                     ymod100_in = 7'd0;
                     qmod4_in   = qmod4_ff + 2'd1;
                  end else begin
                     ymod100_in = ymod100_ff + 7'd1;
                  end
               end else begin
                  w_month_in = w_month_ff + 4'd1;
               end
            end else begin
               // Back to the last day of the previous month.
               rem_in     = rem_ff - AMOUNT_BITS'(w_day_ff);
               w_month_in = prev_month;
               w_day_in   = len_prev;
               if (w_month_ff == 4'd1) begin
                  w_year_in = w_year_ff - 14'd1;
                  ymod4_in  = ymod4_ff - 2'd1;
                  if (ymod100_ff == 7'd0) begin
                     ymod100_in = 7'd99;
                     qmod4_in   = qmod4_ff - 2'd1;
                  end else begin
                     ymod100_in = ymod100_ff - 7'd1;
                  end
               end
            end
         end
         OP_MON_T: begin
            t_in = $signed(mon_base) + TW'(amt_ff);
         end
         OP_MON_DIV: begin
            q12_in = prod12[30:17];
         end
         OP_MON_SET: begin
            w_year_in  = q12_ff;
            w_month_in = 4'(t17 - 17'(q12_ff) * 17'd12) + 4'd1;
         end
         OP_YR_T: begin
            t_in = $signed(TW'(w_year_ff)) + TW'(amt_ff);
         end
         OP_YR_SET: begin
            w_year_in = t_ff[13:0];
         end
         OP_CLAMP: begin
            if (w_day_ff > len_cur) begin
               w_day_in = len_cur;
            end
         end
         OP_ERR_LOAD: begin
            w_year_in  = cur_year_ff;
            w_month_in = cur_month_ff;
            w_day_in   = cur_day_ff;
            err_in     = ERR_BAD_LOAD;
         end
         OP_ERR_RANGE: begin
            w_year_in  = cur_year_ff;
            w_month_in = cur_month_ff;
            w_day_in   = cur_day_ff;
            err_in     = ERR_RANGE;
         end
         OP_WD_DIV: begin
            q100_in = prod100[26:19];
         end
         OP_WD_SUM: begin
            wsum_in = 14'(w_day_ff) + yy + (yy >> 2) - 14'(q100_ff)
                    + 14'(q100_ff >> 2) + month_term(w_month_ff);
         end
         OP_WD_DIV7: begin
            q7_in = prod7[30:19];
         end
         OP_WD_MOD: begin
            wd_in = 3'(wsum_ff - 14'(q7_ff) * 14'd7);
         end
         OP_COMMIT: begin
            cur_year_in  = w_year_ff;
            cur_month_in = w_month_ff;
            cur_day_in   = w_day_ff;
            rsp_valid_in = 1'b1;
            rsp_year_in  = w_year_ff;
            rsp_month_in = w_month_ff;
            rsp_day_in   = w_day_ff;
            rsp_wd_in    = wd_ff;
            rsp_err_in   = err_ff;
         end
         default: begin
         end
      endcase
   end

   // Control state and the stored date.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_year_ff  <= 14'(RESET_YEAR);
         cur_month_ff <= 4'(RESET_MONTH);
         cur_day_ff   <= 5'(RESET_DAY);
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_year_ff  <= cur_year_in;
         cur_month_ff <= cur_month_in;
         cur_day_ff   <= cur_day_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      w_year_ff    <= w_year_in;
      w_month_ff   <= w_month_in;
      w_day_ff     <= w_day_in;
      amt_ff       <= amt_in;
      rem_ff       <= rem_in;
      neg_ff       <= neg_in;
      t_ff         <= t_in;
      q12_ff       <= q12_in;
      q100_ff      <= q100_in;
      ymod4_ff     <= ymod4_in;
      ymod100_ff   <= ymod100_in;
      qmod4_ff     <= qmod4_in;
      wsum_ff      <= wsum_in;
      q7_ff        <= q7_in;
      wd_ff        <= wd_in;
      err_ff       <= err_in;
      rsp_year_ff  <= rsp_year_in;
      rsp_month_ff <= rsp_month_in;
      rsp_day_ff   <= rsp_day_in;
      rsp_wd_ff    <= rsp_wd_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_year    = rsp_year_ff;
   assign rsp_month   = rsp_month_ff;
   assign rsp_day     = rsp_day_ff;
   assign rsp_weekday = rsp_wd_ff;
   assign rsp_error   = rsp_err_ff;

endmodule

`default_nettype wire

### rtl/gda_checker.sv
// ============================================================================
// gda_checker
// Port-level checks on the date arithmetic unit, bound to the top level.
// ============================================================================
`default_nettype none

module gda_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [13:0] rsp_year,
   input wire logic [3:0]  rsp_month,
   input wire logic [4:0]  rsp_day,
   input wire logic [2:0]  rsp_weekday,
   input wire logic [1:0]  rsp_error
);
   import gda_pkg::*;

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_year)
         && $stable(rsp_month) && $stable(rsp_day) && $stable(rsp_weekday)
         && $stable(rsp_error))
      else $error("result changed while stalled");

   // Reported dates always lie inside the legal span.
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_year >= 14'(MIN_YEAR) && rsp_year <= 14'(MAX_YEAR)
         && rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day >= 5'd1)
      else $error("result date out of range");

   // Weekday and error codes stay within their meanings.
   a_rsp_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_weekday != 3'd7 && rsp_error != 2'd3)
      else $error("bad weekday or error code");

   // Only one request is in flight: the port closes after an acceptance.
   a_one_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // No result straight out of reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind gregorian_date_arithmetic_unit gda_checker u_gda_checker (.*);

`default_nettype wire
